@@ src/trsdl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trsdl_pkg
// Shared types, register codes and helpers of the trackpad scroll lock unit.
// ----------------------------------------------------------------------------
package trsdl_pkg;

  // Default width of the signed motion deltas.
  localparam int unsigned DELTA_BITS_DEF = 13;

  // Scroll gain is in hundredths: counts are (remainder + delta * speed) / 100.
  localparam int unsigned SCROLL_DIV = 100;

  // Largest magnitude of a wheel count.
  localparam int unsigned SAT_MAX = 127;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCROLL_SPEED = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_HORIZONTAL = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_VERTICAL = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] SCROLL_SPEED_RST = 8'd100;

  // Direction lock.
  typedef enum logic [3:0] {
    LOCK_UNDECIDED  = 4'b0001,
    LOCK_VERTICAL   = 4'b0010,
    LOCK_HORIZONTAL = 4'b0100,
    LOCK_BOTH       = 4'b1000
  } axis_lock_e;

  // Per-item control flags carried from the input stage to the lock core.
  typedef struct packed {
    logic restart;   // clear remainders and lock before this item
    logic vert_dom;  // current and previous deltas both 2x vertical
    logic horz_dom;  // current and previous deltas both 2x horizontal
  } item_ctl_t;

  // Apply a sign to a clamped 7-bit magnitude.
  function automatic logic signed [7:0] signed_count(input logic neg,
                                                     input logic [6:0] mag);
    logic signed [7:0] pos;
    pos = $signed({1'b0, mag});
    return neg ? -pos : pos;
  endfunction

endpackage
`default_nettype wire

@@ src/trackpad_scroll_direction_lock_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trackpad_scroll_direction_lock_unit
// Turns trackpad motion reports into wheel counts with a direction lock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one motion report per
//   item: current and previous X/Y deltas and a restart flag. Output channel
//   (out_valid_o / out_stall_i) returns one item per report with the
//   vertical and horizontal wheel counts. An item moves when valid is high
//   and stall is low.
//   Path: an accepted item waits in the input register, then passes through
//   the divide and lock logic into the result register that drives the output.
//   Throughput: one item per cycle while the output is not stalled. Each item
//   reads and updates the remainders and lock in one pass (add, reciprocal
//   multiply by 1/100, one correction), which is what bounds the cycle.
//   Stall: while the result register is held, the input register keeps its
//   item and in_stall_o rises once it is full; an empty result register
//   never stalls the input.
//   Reset: remainders clear, the lock goes undecided, both channels empty,
//   and the gain returns to 100 with both reversals off. Configuration:
//   cfg_we_i writes cfg_data_i to register cfg_index_i (0 speed, 1 reverse
//   horizontal, 2 reverse vertical); users write only while idle, unenforced.
// ----------------------------------------------------------------------------
module trackpad_scroll_direction_lock_unit import trsdl_pkg::*; #(
  parameter int unsigned DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // motion reports
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [DELTA_BITS-1:0]  delta_x_i,
  input  logic signed [DELTA_BITS-1:0]  delta_y_i,
  input  logic signed [DELTA_BITS-1:0]  prev_delta_x_i,
  input  logic signed [DELTA_BITS-1:0]  prev_delta_y_i,
  input  logic                          restart_i,
  // wheel counts
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [7:0]             wheel_vertical_o,
  output logic signed [7:0]             wheel_horizontal_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  localparam int unsigned ProdW = DELTA_BITS + 9;

  logic [7:0]              scroll_speed_q;
  logic                    reverse_horizontal_q;
  logic                    reverse_vertical_q;

  logic                    fire;
  logic                    stage_valid;
  logic signed [ProdW-1:0] prod_x;
  logic signed [ProdW-1:0] prod_y;
  item_ctl_t               stage_ctl;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_speed_q       <= SCROLL_SPEED_RST;
      reverse_horizontal_q <= 1'b0;
      reverse_vertical_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCROLL_SPEED:       scroll_speed_q       <= cfg_data_i;
        CFG_REVERSE_HORIZONTAL: reverse_horizontal_q <= cfg_data_i[0];
        CFG_REVERSE_VERTICAL:   reverse_vertical_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Scale the deltas and precompute delta dominance on the way in.
  trsdl_in_stage #(.DELTA_BITS(DELTA_BITS)) u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .delta_x_i      (delta_x_i),
    .delta_y_i      (delta_y_i),
    .prev_delta_x_i (prev_delta_x_i),
    .prev_delta_y_i (prev_delta_y_i),
    .restart_i      (restart_i),
    .scroll_speed_i (scroll_speed_q),
    .fire_i         (fire),
    .valid_o        (stage_valid),
    .prod_x_o       (prod_x),
    .prod_y_o       (prod_y),
    .ctl_o          (stage_ctl)
  );

  // Accumulate, divide, advance the lock and register the result.
  trsdl_core #(.DELTA_BITS(DELTA_BITS)) u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (stage_valid),
    .prod_x_i             (prod_x),
    .prod_y_i             (prod_y),
    .ctl_i                (stage_ctl),
    .reverse_horizontal_i (reverse_horizontal_q),
    .reverse_vertical_i   (reverse_vertical_q),
    .fire_o               (fire),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .wheel_vertical_o     (wheel_vertical_o),
    .wheel_horizontal_o   (wheel_horizontal_o)
  );

endmodule
`default_nettype wire

@@ src/trsdl_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trsdl_in_stage
// Input register: scaled deltas and dominance flags of one motion report.
// ----------------------------------------------------------------------------
module trsdl_in_stage import trsdl_pkg::*; #(
  parameter int unsigned DELTA_BITS = DELTA_BITS_DEF,
  localparam int unsigned ProdW = DELTA_BITS + 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [DELTA_BITS-1:0]  delta_x_i,
  input  logic signed [DELTA_BITS-1:0]  delta_y_i,
  input  logic signed [DELTA_BITS-1:0]  prev_delta_x_i,
  input  logic signed [DELTA_BITS-1:0]  prev_delta_y_i,
  input  logic                          restart_i,
  input  logic [7:0]                    scroll_speed_i,
  input  logic                          fire_i,
  output logic                          valid_o,
  output logic signed [ProdW-1:0]       prod_x_o,
  output logic signed [ProdW-1:0]       prod_y_o,
  output item_ctl_t                     ctl_o
);

  logic                    valid_q, valid_d;
  logic                    accept;
  logic signed [8:0]       speed_s;
  logic signed [ProdW-1:0] prod_x_d, prod_x_q;
  logic signed [ProdW-1:0] prod_y_d, prod_y_q;
  item_ctl_t               ctl_d, ctl_q;

  // one bit wider than the delta so the most negative value keeps its size
  function automatic logic [DELTA_BITS:0] magnitude(input logic signed [DELTA_BITS-1:0] v);
    logic signed [DELTA_BITS:0] w;
    w = {v[DELTA_BITS-1], v};
    if (w < 0) begin
      w = -w;
    end
    return w;
  endfunction

  // major dominates minor when |major| > 2 * |minor|
  function automatic logic dominates(input logic signed [DELTA_BITS-1:0] major,
                                     input logic signed [DELTA_BITS-1:0] minor);
    logic [DELTA_BITS+1:0] a;
    logic [DELTA_BITS+1:0] b;
    a = {1'b0, magnitude(major)};
    b = {magnitude(minor), 1'b0};
    return a > b;
  endfunction

  assign in_stall_o = valid_q && !fire_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign speed_s  = $signed({1'b0, scroll_speed_i});
  assign prod_x_d = ProdW'(delta_x_i) * ProdW'(speed_s);
  assign prod_y_d = ProdW'(delta_y_i) * ProdW'(speed_s);

  always_comb begin
    ctl_d.restart  = restart_i;
    ctl_d.vert_dom = dominates(delta_y_i, delta_x_i) &&
                     dominates(prev_delta_y_i, prev_delta_x_i);
    ctl_d.horz_dom = dominates(delta_x_i, delta_y_i) &&
                     dominates(prev_delta_x_i, prev_delta_y_i);
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      ctl_q    <= ctl_d;
    end
  end

  assign valid_o  = valid_q;
  assign prod_x_o = prod_x_q;
  assign prod_y_o = prod_y_q;
  assign ctl_o    = ctl_q;

endmodule
`default_nettype wire

@@ src/trsdl_div100.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trsdl_div100
// Signed divide by 100, truncated toward zero, via reciprocal multiply.
// ----------------------------------------------------------------------------
module trsdl_div100 import trsdl_pkg::*; #(
  parameter int unsigned DELTA_BITS = DELTA_BITS_DEF,
  localparam int unsigned SumW = DELTA_BITS + 9,
  localparam int unsigned QuotW = DELTA_BITS + 1
) (
  input  logic signed [SumW-1:0] sum_i,
  output logic                   neg_o,
  output logic [QuotW-1:0]       quot_o,
  output logic signed [7:0]      rem_o
);

  // |sum| < 2^MagW, so floor(2^MagW / 100) under-estimates by at most one
  localparam int unsigned MagW = DELTA_BITS + 7;
  localparam logic [MagW-1:0] Recip = MagW'((64'd1 << MagW) / SCROLL_DIV);

  logic [SumW-1:0]     abs_w;
  logic [MagW-1:0]     mag;
  logic [2*MagW-1:0]   prod;
  logic [QuotW-1:0]    q_est;
  logic [QuotW+6:0]    q_x100;
  logic [MagW-1:0]     r_wide;
  logic [7:0]          r8;
  logic [6:0]          r7;

  assign neg_o  = sum_i[SumW-1];
  assign abs_w  = neg_o ? SumW'(-sum_i) : SumW'(sum_i);
  assign mag    = abs_w[MagW-1:0];
  assign prod   = (2*MagW)'(mag) * (2*MagW)'(Recip);
  assign q_est  = prod[MagW +: QuotW];
  assign q_x100 = (QuotW + 7)'(q_est) * (QuotW + 7)'(SCROLL_DIV);
  assign r_wide = mag - q_x100[MagW-1:0];
  assign r8     = r_wide[7:0];

  // one correction step: the estimate is the quotient or one below it
  always_comb begin
    if (r8 >= 8'(SCROLL_DIV)) begin
      quot_o = q_est + QuotW'(1);
      r7     = 7'(r8 - 8'(SCROLL_DIV));
    end else begin
      quot_o = q_est;
      r7     = r8[6:0];
    end
  end

  assign rem_o = signed_count(neg_o, r7);

endmodule
`default_nettype wire

@@ src/trsdl_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trsdl_core
// Remainder accumulation, direction lock and the result register.
// ----------------------------------------------------------------------------
module trsdl_core import trsdl_pkg::*; #(
  parameter int unsigned DELTA_BITS = DELTA_BITS_DEF,
  localparam int unsigned ProdW = DELTA_BITS + 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic signed [ProdW-1:0]  prod_x_i,
  input  logic signed [ProdW-1:0]  prod_y_i,
  input  item_ctl_t                ctl_i,
  input  logic                     reverse_horizontal_i,
  input  logic                     reverse_vertical_i,
  output logic                     fire_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [7:0]        wheel_vertical_o,
  output logic signed [7:0]        wheel_horizontal_o
);

  localparam int unsigned QuotW = DELTA_BITS + 1;

  logic signed [7:0]  rem_x_q, rem_y_q;
  logic signed [7:0]  rem_x_eff, rem_y_eff;
  logic signed [7:0]  rem_x_d, rem_y_d;
  axis_lock_e         lock_q, lock_eff, lock_d;
  logic signed [ProdW-1:0] sum_x, sum_y;
  logic               neg_x, neg_y;
  logic [QuotW-1:0]   q_x, q_y;
  logic               cnt_y_dom, cnt_x_dom;
  logic               en_v, en_h;
  logic [6:0]         mag_v, mag_h;
  logic signed [7:0]  wheel_v_d, wheel_h_d;
  logic signed [7:0]  wheel_v_q, wheel_h_q;
  logic               out_valid_q, out_valid_d;

  assign fire_o = in_valid_i && (!out_valid_q || !out_stall_i);

  // restart clears the state ahead of this item
  assign rem_x_eff = ctl_i.restart ? 8'sd0 : rem_x_q;
  assign rem_y_eff = ctl_i.restart ? 8'sd0 : rem_y_q;
  assign lock_eff  = ctl_i.restart ? LOCK_UNDECIDED : lock_q;

  assign sum_x = ProdW'(rem_x_eff) + prod_x_i;
  assign sum_y = ProdW'(rem_y_eff) + prod_y_i;

  trsdl_div100 #(.DELTA_BITS(DELTA_BITS)) u_div_x (
    .sum_i  (sum_x),
    .neg_o  (neg_x),
    .quot_o (q_x),
    .rem_o  (rem_x_d)
  );

  trsdl_div100 #(.DELTA_BITS(DELTA_BITS)) u_div_y (
    .sum_i  (sum_y),
    .neg_o  (neg_y),
    .quot_o (q_y),
    .rem_o  (rem_y_d)
  );

  assign cnt_y_dom = (QuotW + 1)'(q_y) > {q_x, 1'b0};
  assign cnt_x_dom = (QuotW + 1)'(q_x) > {q_y, 1'b0};

  always_comb begin
    lock_d = lock_eff;
    unique case (lock_eff)
      LOCK_UNDECIDED: begin
        if (q_x != '0 || q_y != '0) begin
          if (cnt_y_dom) begin
            lock_d = LOCK_VERTICAL;
          end else if (cnt_x_dom) begin
            lock_d = LOCK_HORIZONTAL;
          end else begin
            lock_d = LOCK_BOTH;
          end
        end
      end
      LOCK_VERTICAL: begin
        if (ctl_i.horz_dom) begin
          lock_d = LOCK_BOTH;
        end
      end
      LOCK_HORIZONTAL: begin
        if (ctl_i.vert_dom) begin
          lock_d = LOCK_BOTH;
        end
      end
      LOCK_BOTH: begin
        lock_d = LOCK_BOTH;
      end
      default: begin
        lock_d = LOCK_UNDECIDED;
      end
    endcase
  end

  // the deciding item itself still shows zero
  assign en_v = (lock_eff != LOCK_UNDECIDED) &&
                (lock_d == LOCK_VERTICAL || lock_d == LOCK_BOTH);
  assign en_h = (lock_eff != LOCK_UNDECIDED) &&
                (lock_d == LOCK_HORIZONTAL || lock_d == LOCK_BOTH);

  assign mag_v = (q_y > QuotW'(SAT_MAX)) ? 7'(SAT_MAX) : q_y[6:0];
  assign mag_h = (q_x > QuotW'(SAT_MAX)) ? 7'(SAT_MAX) : q_x[6:0];

  assign wheel_v_d = en_v ? signed_count(neg_y ^ reverse_vertical_i, mag_v) : 8'sd0;
  assign wheel_h_d = en_h ? signed_count(neg_x ^ reverse_horizontal_i, mag_h) : 8'sd0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_x_q     <= 8'sd0;
      rem_y_q     <= 8'sd0;
      lock_q      <= LOCK_UNDECIDED;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire_o) begin
        rem_x_q <= rem_x_d;
        rem_y_q <= rem_y_d;
        lock_q  <= lock_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_o) begin
      wheel_v_q <= wheel_v_d;
      wheel_h_q <= wheel_h_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign wheel_vertical_o   = wheel_v_q;
  assign wheel_horizontal_o = wheel_h_q;

endmodule
`default_nettype wire

@@ src/trsdl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trsdl_checker
// Port-level checks of the trackpad scroll lock unit, bound to the top level.
// ----------------------------------------------------------------------------
module trsdl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input logic signed [7:0] wheel_vertical_i,
  input logic signed [7:0] wheel_horizontal_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // an empty result register never back-pressures the input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> !in_stall_i)
    else $error("input stalled with empty result register");

  // counts saturate symmetrically, never reaching -128
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (wheel_vertical_i != -8'sd128) && (wheel_horizontal_i != -8'sd128))
    else $error("wheel count outside saturation range");

  // an item accepted into an idle block is not lost on its way to the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && !out_valid_i && !in_stall_i |=> ##1
      (out_valid_i || $past(out_stall_i)) || out_valid_i)
    else $error("item lost between input and result register");

endmodule

bind trackpad_scroll_direction_lock_unit trsdl_checker u_trsdl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_i         (in_stall_o),
  .out_valid_i        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .wheel_vertical_i   (wheel_vertical_o),
  .wheel_horizontal_i (wheel_horizontal_o)
);
`default_nettype wire

@@ dv/scroll_lock_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scroll_lock_checker
// Watches both channels of the scroll lock unit and checks every wheel item.
// ----------------------------------------------------------------------------
module scroll_lock_checker import trsdl_pkg::*; #(
  parameter int unsigned DW = DELTA_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [DW-1:0]    delta_x_i,
  input  logic signed [DW-1:0]    delta_y_i,
  input  logic signed [DW-1:0]    prev_delta_x_i,
  input  logic signed [DW-1:0]    prev_delta_y_i,
  input  logic                    restart_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [7:0]       wheel_vertical_i,
  input  logic signed [7:0]       wheel_horizontal_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [7:0]              cfg_data_i,
  output int                      err_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  typedef struct {
    logic signed [7:0] vert;
    logic signed [7:0] horiz;
  } wheel_t;

  wheel_t     wheel_q[$];

  // shadow of the registers and of the scroll state
  logic [7:0] speed;
  logic       rev_h;
  logic       rev_v;
  int         rem_x;
  int         rem_y;
  axis_lock_e lock;

  function automatic bit twice_over(input int major, input int minor);
    int am;
    int an;
    am = (major < 0) ? -major : major;
    an = (minor < 0) ? -minor : minor;
    return am > 2 * an;
  endfunction

  function automatic logic signed [7:0] clip_wheel(input int v);
    if (v > int'(SAT_MAX)) v = SAT_MAX;
    if (v < -int'(SAT_MAX)) v = -int'(SAT_MAX);
    return v[7:0];
  endfunction

  task automatic scroll_lock_predict(input logic signed [DW-1:0] dx,
                                     input logic signed [DW-1:0] dy,
                                     input logic signed [DW-1:0] px,
                                     input logic signed [DW-1:0] py,
                                     input logic rs,
                                     output wheel_t w);
    int sum_x;
    int sum_y;
    int cnt_x;
    int cnt_y;
    w.vert  = '0;
    w.horiz = '0;
    if (rs) begin
      rem_x = 0;
      rem_y = 0;
      lock  = LOCK_UNDECIDED;
    end
    sum_x = rem_x + int'(dx) * int'(speed);
    sum_y = rem_y + int'(dy) * int'(speed);
    cnt_x = sum_x / int'(SCROLL_DIV);
    cnt_y = sum_y / int'(SCROLL_DIV);
    rem_x = sum_x - cnt_x * int'(SCROLL_DIV);
    rem_y = sum_y - cnt_y * int'(SCROLL_DIV);
    if (lock == LOCK_UNDECIDED) begin
      // the deciding item itself scrolls nothing
      if (cnt_x != 0 || cnt_y != 0) begin
        if (twice_over(cnt_y, cnt_x)) lock = LOCK_VERTICAL;
        else if (twice_over(cnt_x, cnt_y)) lock = LOCK_HORIZONTAL;
        else lock = LOCK_BOTH;
      end
    end else begin
      // widen on two dominant reports in a row on the locked-out axis
      if (twice_over(int'(dy), int'(dx)) && twice_over(int'(py), int'(px))) begin
        if (lock == LOCK_HORIZONTAL) lock = LOCK_BOTH;
      end else if (twice_over(int'(dx), int'(dy)) && twice_over(int'(px), int'(py))) begin
        if (lock == LOCK_VERTICAL) lock = LOCK_BOTH;
      end
      if (lock == LOCK_VERTICAL || lock == LOCK_BOTH)
        w.vert = clip_wheel(rev_v ? -cnt_y : cnt_y);
      if (lock == LOCK_HORIZONTAL || lock == LOCK_BOTH)
        w.horiz = clip_wheel(rev_h ? -cnt_x : cnt_x);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_t w;
    wheel_t want;
    if (!rst_ni) begin
      wheel_q.delete();
      speed       = SCROLL_SPEED_RST;
      rev_h       = 1'b0;
      rev_v       = 1'b0;
      rem_x       = 0;
      rem_y       = 0;
      lock        = LOCK_UNDECIDED;
      err_count_o = 0;
      checked_o   = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SCROLL_SPEED:       speed = cfg_data_i;
          CFG_REVERSE_HORIZONTAL: rev_h = cfg_data_i[0];
          CFG_REVERSE_VERTICAL:   rev_v = cfg_data_i[0];
          default: ;
        endcase
      end
      // compare before pushing: a result never leaves in its own cycle
      if (out_valid_i && !out_stall_i) begin
        if (wheel_q.size() == 0) begin
          $display("%0t wheel item with nothing expected: vert %0d horiz %0d",
                   $time, wheel_vertical_i, wheel_horizontal_i);
          err_count_o++;
        end else begin
          want = wheel_q.pop_front();
          checked_o++;
          if (wheel_vertical_i !== want.vert) begin
            $display("%0t wheel_vertical expected %0d got %0d",
                     $time, want.vert, wheel_vertical_i);
            err_count_o++;
          end
          if (wheel_horizontal_i !== want.horiz) begin
            $display("%0t wheel_horizontal expected %0d got %0d",
                     $time, want.horiz, wheel_horizontal_i);
            err_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        scroll_lock_predict(delta_x_i, delta_y_i, prev_delta_x_i, prev_delta_y_i,
                            restart_i, w);
        wheel_q.push_back(w);
      end
      pending_o <= wheel_q.size();
    end
  end

endmodule

@@ dv/trackpad_scroll_direction_lock_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trackpad_scroll_direction_lock_unit_test
// Drives motion reports and register writes into the scroll lock unit.
// A checker beside the block predicts each wheel item; this top only makes
// stimulus: directed corner reports, then gestures with random content,
// random gaps and stalls, and one long output hold-off.
// ----------------------------------------------------------------------------
module trackpad_scroll_direction_lock_unit_test;
  import trsdl_pkg::*;

  localparam int unsigned DW           = DELTA_BITS_DEF;
  localparam int          PHASES       = 5;
  localparam int          PHASE_ITEMS  = 300;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          RUN_LIMIT_NS = 8_000_000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [DW-1:0]    delta_x = '0;
  logic signed [DW-1:0]    delta_y = '0;
  logic signed [DW-1:0]    prev_delta_x = '0;
  logic signed [DW-1:0]    prev_delta_y = '0;
  logic                    restart = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [7:0]       wheel_vertical;
  logic signed [7:0]       wheel_horizontal;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [7:0]              cfg_data = '0;

  int err_count;
  int pending;
  int checked;

  // shared between the sender and the output stall process
  bit calm = 1'b0;      // no gaps and no stalls on either side
  bit hold_req = 1'b0;  // ask for one long output hold-off

  int sent = 0;
  int restarts = 0;
  int reg_writes = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  trackpad_scroll_direction_lock_unit #(.DELTA_BITS(DW)) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .delta_x_i          (delta_x),
    .delta_y_i          (delta_y),
    .prev_delta_x_i     (prev_delta_x),
    .prev_delta_y_i     (prev_delta_y),
    .restart_i          (restart),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .wheel_vertical_o   (wheel_vertical),
    .wheel_horizontal_o (wheel_horizontal),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  scroll_lock_checker #(.DW(DW)) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .delta_x_i          (delta_x),
    .delta_y_i          (delta_y),
    .prev_delta_x_i     (prev_delta_x),
    .prev_delta_y_i     (prev_delta_y),
    .restart_i          (restart),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .wheel_vertical_i   (wheel_vertical),
    .wheel_horizontal_i (wheel_horizontal),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .err_count_o        (err_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  // Mostly zero or short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Magnitude of one motion delta: mostly small, some large, a few full scale.
  function automatic int motion_mag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 40);
    if (r < 90) return $urandom_range(0, 400);
    return $urandom_range(0, 4095);
  endfunction

  function automatic logic signed [DW-1:0] with_sign(input int m);
    return $urandom_range(0, 1) ? DW'(-m) : DW'(m);
  endfunction

  // Offer one report and hold it until the block takes it. Valid stays high
  // into the next item when no gap is drawn.
  task automatic offer_report(input logic signed [DW-1:0] dx,
                              input logic signed [DW-1:0] dy,
                              input logic signed [DW-1:0] px,
                              input logic signed [DW-1:0] py,
                              input logic rs);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    delta_x      <= dx;
    delta_y      <= dy;
    prev_delta_x <= px;
    prev_delta_y <= py;
    restart      <= rs;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
    if (rs) restarts++;
  endtask

  // Drop valid and wait until every wheel item has come back, plus some
  // margin, so the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    reg_writes++;
  endtask

  // One gesture: restart first, then reports whose previous deltas are the
  // ones really sent before, mostly dominant on one axis.
  task automatic run_gesture(input int len);
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] last_x;
    logic signed [DW-1:0] last_y;
    int                   major;
    int                   r;
    last_x = '0;
    last_y = '0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      major = motion_mag();
      if (major == 0) major = 1;
      if (r < 40) begin
        dy = with_sign(major);
        dx = with_sign($urandom_range(0, major / 2));
      end else if (r < 80) begin
        dx = with_sign(major);
        dy = with_sign($urandom_range(0, major / 2));
      end else if (r < 95) begin
        dx = with_sign(motion_mag());
        dy = with_sign(motion_mag());
      end else begin
        dx = '0;
        dy = '0;
      end
      offer_report(dx, dy, last_x, last_y, i == 0);
      last_x = dx;
      last_y = dy;
    end
  endtask

  // Output side: random stalls, none while calm, and one long hold-off on
  // request, counted here while the sender keeps offering.
  initial begin : out_stall_drive
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int phase_sent;
    int r;
    bit hold_asked;
    hold_asked = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: speed 100, no reversal.
    offer_report(0, 0, 0, 0, 1'b0);              // undecided, nothing moves
    offer_report(4095, 0, 0, 0, 1'b0);           // decides horizontal, still zero
    offer_report(-4096, 0, 4095, 0, 1'b0);       // horizontal saturates low
    offer_report(0, -4096, 0, -4096, 1'b0);      // vertical twice: widen to both
    offer_report(4095, 4095, -4096, -4096, 1'b0); // both saturate high
    offer_report(1, 1, 0, 0, 1'b1);              // restart, decides both
    offer_report(0, 5, 0, 0, 1'b1);              // restart, decides vertical
    offer_report(3, 0, 3, 0, 1'b0);              // horizontal twice: widen
    offer_report(4, -2, 3, 0, 1'b0);             // dominance tie is not dominance

    // Largest gain with both axes reversed.
    settle();
    write_reg(CFG_SCROLL_SPEED, 8'd255);
    write_reg(CFG_REVERSE_HORIZONTAL, 8'd1);
    write_reg(CFG_REVERSE_VERTICAL, 8'd1);
    offer_report(0, 0, 0, 0, 1'b1);
    offer_report(1, 0, 0, 0, 1'b0);              // carries a remainder, decides
    offer_report(-1, 0, 1, 0, 1'b0);
    offer_report(4095, -4096, -1, 0, 1'b0);      // reversed and clamped
    offer_report(0, -4096, 0, -4096, 1'b0);
    offer_report(-17, 3, 0, -4096, 1'b0);

    // Zero gain: counts stay zero and the lock stays undecided.
    settle();
    write_reg(CFG_SCROLL_SPEED, 8'd0);
    offer_report(4095, 0, 0, 0, 1'b1);
    offer_report(-4096, -4096, 0, 0, 1'b0);
    offer_report(100, -3, 100, -3, 1'b0);

    // Odd gain to build up remainders; the spare index must do nothing.
    settle();
    write_reg(CFG_IDX_BITS'(3), 8'($urandom));
    write_reg(CFG_SCROLL_SPEED, 8'd37);
    write_reg(CFG_REVERSE_HORIZONTAL, 8'd0);
    write_reg(CFG_REVERSE_VERTICAL, 8'd0);
    offer_report(1, 0, 0, 0, 1'b1);
    for (int i = 0; i < 4; i++) offer_report(1, 0, 1, 0, 1'b0);
    offer_report(-1, -2, 1, 0, 1'b0);

    // Random phases: gestures with random content plus noise.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        1:       write_reg(CFG_SCROLL_SPEED, 8'd255);
        2:       write_reg(CFG_SCROLL_SPEED, 8'd1);
        default: write_reg(CFG_SCROLL_SPEED, 8'($urandom));
      endcase
      write_reg(CFG_REVERSE_HORIZONTAL, 8'($urandom_range(0, 1)));
      write_reg(CFG_REVERSE_VERTICAL, 8'($urandom_range(0, 1)));
      calm = (p == 0);
      phase_sent = sent;
      while (sent - phase_sent < PHASE_ITEMS) begin
        // hold the output off early in the calm phase to fill the block
        if (p == 0 && !hold_asked && sent - phase_sent >= 50) begin
          hold_req   = 1'b1;
          hold_asked = 1'b1;
        end
        if (p == 0 && sent - phase_sent >= 150) calm = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 15) begin
          offer_report(DW'($urandom), DW'($urandom), DW'($urandom), DW'($urandom),
                       1'($urandom));
        end else begin
          run_gesture($urandom_range(2, 16));
        end
      end
    end
    calm = 1'b0;

    settle();
    repeat (5) @(posedge clk_i);
    $display("covered %0d reports (%0d restarts), %0d wheel items compared",
             sent, restarts, checked);
    $display("across %0d register writes, gains 0 to 255, both reversals", reg_writes);
    if (err_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
